FILE: hw/rtl/best_fit_heap_allocator_assert.svh
// Assertion macros shared by the best-fit heap allocator RTL.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define BFHA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition in one cycle implies an expression in the next.
`define BFHA_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) else $error(msg);
`else
`define BFHA_ASSERT(lbl, clk, rstn, prop, msg)
`define BFHA_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg)
`endif
`endif

FILE: hw/rtl/bfha_pkg.sv
// Shared widths, codes and types of the best-fit heap allocator.
package bfha_pkg;

    localparam int REQ_W    = 13;  // request_bytes field
    localparam int OFF_W    = 12;  // payload_offset and granted_offset fields
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 16;  // one heap word
    localparam int SZ_W     = 14;  // rounded block size of a request

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_NO_FIT = 2'd1,
        STAT_REJECT = 2'd2
    } status_t;

    // One finished result from the sequencer.
    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] granted;
        status_t          status;
    } res_t;

endpackage

FILE: hw/rtl/bfha_heap.sv
// Heap word memory with registered read and a reset initialization sweep.
module bfha_heap #(
    parameter int HEAP_BYTES = 4096,
    parameter int AW         = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bfha_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [bfha_pkg::WORD_W-1:0] rdata,
    output logic                        ready
);
    import bfha_pkg::*;

    localparam int WORDS = HEAP_BYTES / 4;
    localparam logic [AW-1:0] HDR_IDX  = AW'(1);
    localparam logic [AW-1:0] FTR_IDX  = AW'((HEAP_BYTES - 8) / 4);
    localparam logic [AW-1:0] LAST_IDX = AW'(WORDS - 1);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     init_idx_reg;
    logic              init_busy_reg;
    logic [WORD_W-1:0] init_word;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Reset image: one free block after the padding word, its footer, end mark
    always_comb begin
        if (init_idx_reg == HDR_IDX) begin
            init_word = WORD_W'(HEAP_BYTES - 6);
        end else if (init_idx_reg == FTR_IDX) begin
            init_word = WORD_W'(HEAP_BYTES - 8);
        end else if (init_idx_reg == LAST_IDX) begin
            init_word = WORD_W'(1);
        end else begin
            init_word = '0;
        end
    end

    // Select the sweep or the sequencer as the write source
    always_comb begin
        mem_we    = init_busy_reg | we;
        mem_waddr = init_busy_reg ? init_idx_reg : waddr;
        mem_wdata = init_busy_reg ? init_word : wdata;
    end

    // Advance the initialization sweep, one word per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            init_idx_reg  <= '0;
        end else if (init_busy_reg) begin
            init_idx_reg <= init_idx_reg + AW'(1);
            if (init_idx_reg == LAST_IDX) begin
                init_busy_reg <= 1'b0;
            end
        end
    end

    // Write one word and read one word per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign ready = !init_busy_reg;

endmodule

FILE: hw/rtl/bfha_seq.sv
// Sequencer that walks the block list and updates boundary tags per request.
`include "best_fit_heap_allocator_assert.svh"

module bfha_seq #(
    parameter int HEAP_BYTES = 4096,
    parameter int AW         = 10,
    parameter int OW         = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [bfha_pkg::REQ_W-1:0]  s_request_bytes,
    input  logic [bfha_pkg::OFF_W-1:0]  s_payload_offset,
    input  logic                        heap_ready,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [bfha_pkg::WORD_W-1:0] ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  logic [bfha_pkg::WORD_W-1:0] ram_rdata,
    input  logic                        out_free,
    output bfha_pkg::res_t              res
);
    import bfha_pkg::*;

    localparam int CW = (OW > SZ_W) ? OW : SZ_W;
    localparam logic [OW-1:0] END_OFF   = OW'(HEAP_BYTES - 4);
    localparam logic [OW-1:0] FIRST_OFF = OW'(4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_WALK,
        ST_A_NEXT,
        ST_A_NRD,
        ST_A_WH,
        ST_A_WF,
        ST_A_WB,
        ST_F_WALK,
        ST_F_LD,
        ST_F_RD,
        ST_F_WL,
        ST_F_WF,
        ST_DONE
    } state_t;

    state_t          state_reg;
    res_t            res_reg;
    logic [OW-1:0]   off_reg;
    logic [OW-1:0]   h_reg;
    logic [SZ_W-1:0] size_reg;
    logic            found_reg;
    logic [OW-1:0]   best_reg;
    logic [OW-1:0]   bsize_reg;
    logic [CW-1:0]   bdiff_reg;
    logic [OW-1:0]   nxt_reg;
    logic [OW-1:0]   nh_reg;
    logic [OW-1:0]   lsize_reg;
    logic [OW-1:0]   left_reg;
    logic [OW-1:0]   total_reg;

    logic [OW-1:0]   rd_sz;
    logic            rd_end;
    logic [OW-1:0]   walk_next;
    logic            next_past;
    logic            cand;
    logic [CW-1:0]   cand_diff;
    logic            take;
    logic [SZ_W-1:0] req_round4;
    logic [SZ_W-1:0] req_size;
    logic            free_bad;
    logic            hit;
    logic            merge_left;
    logic [OW-1:0]   lsz_c;
    logic [OW-1:0]   right_off;
    logic            right_live;
    logic [OW-1:0]   rsz_c;
    logic [OW-1:0]   raddr_byte;
    logic [OW-1:0]   waddr_byte;

    // Decode the header word returned by the heap
    always_comb begin
        rd_sz      = {ram_rdata[OW-1:3], 3'b000};
        rd_end     = (ram_rdata == WORD_W'(1)) || (rd_sz == '0);
        walk_next  = off_reg + rd_sz;
        next_past  = walk_next >= END_OFF;
        cand       = !ram_rdata[0] && (CW'(rd_sz) >= CW'(size_reg));
        cand_diff  = CW'(rd_sz) - CW'(size_reg);
        take       = !rd_end && cand && (!found_reg || cand_diff < bdiff_reg);
        hit        = off_reg == h_reg;
        merge_left = !ram_rdata[1] && (h_reg >= OW'(8));
        lsz_c      = (ram_rdata > WORD_W'(h_reg)) ? '0 : OW'(ram_rdata);
        right_off  = h_reg + bsize_reg;
        right_live = (right_off < END_OFF) && (ram_rdata != WORD_W'(1));
        rsz_c      = (right_live && !ram_rdata[0]) ? rd_sz : '0;
    end

    // Round the request up to a word, add the header, round to eight bytes; flag bad frees
    always_comb begin
        req_round4 = (SZ_W'(s_request_bytes) + SZ_W'(3)) & ~SZ_W'(3);
        req_size   = (req_round4 + SZ_W'(11)) & ~SZ_W'(7);
        free_bad   = (s_payload_offset == '0) || (s_payload_offset[2:0] != 3'd0)
                     || (32'(s_payload_offset) >= 32'(HEAP_BYTES));
    end

    // Drive heap addresses and write data for the current step
    always_comb begin
        raddr_byte = '0;
        waddr_byte = '0;
        ram_we     = 1'b0;
        ram_wdata  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                raddr_byte = FIRST_OFF;
            end
            ST_A_WALK: begin
                raddr_byte = walk_next;
            end
            ST_A_NEXT: begin
                raddr_byte = best_reg + bsize_reg;
            end
            ST_A_NRD: begin
                waddr_byte = nxt_reg;
                ram_we     = (nxt_reg != END_OFF) && (ram_rdata != WORD_W'(1));
                ram_wdata  = ram_rdata | WORD_W'(2);
            end
            ST_A_WH: begin
                waddr_byte = nh_reg;
                ram_we     = 1'b1;
                ram_wdata  = WORD_W'(size_reg)
                             + (((nh_reg == OW'(4)) || (bdiff_reg == '0))
                                ? WORD_W'(3) : WORD_W'(1));
            end
            ST_A_WF: begin
                waddr_byte = nh_reg - OW'(4);
                ram_we     = 1'b1;
                ram_wdata  = WORD_W'(bdiff_reg);
            end
            ST_A_WB: begin
                waddr_byte = best_reg;
                ram_we     = 1'b1;
                ram_wdata  = WORD_W'(bdiff_reg) + WORD_W'(2);
            end
            ST_F_WALK: begin
                if (hit && ram_rdata[0]) begin
                    raddr_byte = merge_left ? (h_reg - OW'(4)) : (h_reg + rd_sz);
                end else begin
                    raddr_byte = walk_next;
                end
            end
            ST_F_LD: begin
                waddr_byte = h_reg - OW'(4);
                ram_we     = 1'b1;
                ram_wdata  = '0;
                raddr_byte = right_off;
            end
            ST_F_RD: begin
                waddr_byte = right_off;
                ram_we     = right_live && ram_rdata[0];
                ram_wdata  = ram_rdata & ~WORD_W'(2);
            end
            ST_F_WL: begin
                waddr_byte = left_reg;
                ram_we     = 1'b1;
                ram_wdata  = WORD_W'(total_reg) + WORD_W'(2);
            end
            ST_F_WF: begin
                waddr_byte = left_reg + total_reg - OW'(4);
                ram_we     = 1'b1;
                ram_wdata  = WORD_W'(total_reg);
            end
            default: begin
                raddr_byte = '0;
            end
        endcase
    end

    assign ram_raddr = raddr_byte[AW+1:2];
    assign ram_waddr = waddr_byte[AW+1:2];
    assign s_ready   = (state_reg == ST_IDLE) && heap_ready;
    assign res       = res_reg;

    // Sequence one request at a time and hold its result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_reg.valid <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        off_reg <= FIRST_OFF;
                        if (s_opcode == OP_ALLOC) begin
                            size_reg  <= req_size;
                            found_reg <= 1'b0;
                            state_reg <= ST_A_WALK;
                        end else if (free_bad) begin
                            res_reg.valid   <= 1'b1;
                            res_reg.granted <= '0;
                            res_reg.status  <= STAT_REJECT;
                            state_reg       <= ST_DONE;
                        end else begin
                            h_reg     <= OW'(s_payload_offset) - OW'(4);
                            state_reg <= ST_F_WALK;
                        end
                    end
                end
                ST_A_WALK: begin
                    if (take) begin
                        found_reg <= 1'b1;
                        bdiff_reg <= cand_diff;
                        best_reg  <= off_reg;
                        bsize_reg <= rd_sz;
                    end
                    if (rd_end || next_past) begin
                        if (found_reg || take) begin
                            state_reg <= ST_A_NEXT;
                        end else begin
                            res_reg.valid   <= 1'b1;
                            res_reg.granted <= '0;
                            res_reg.status  <= STAT_NO_FIT;
                            state_reg       <= ST_DONE;
                        end
                    end else begin
                        off_reg <= walk_next;
                    end
                end
                ST_A_NEXT: begin
                    nxt_reg   <= best_reg + bsize_reg;
                    state_reg <= ST_A_NRD;
                end
                ST_A_NRD: begin
                    nh_reg    <= best_reg + bsize_reg - OW'(size_reg);
                    state_reg <= ST_A_WH;
                end
                ST_A_WH: begin
                    if (bdiff_reg != '0) begin
                        state_reg <= ST_A_WF;
                    end else begin
                        res_reg.valid   <= 1'b1;
                        res_reg.granted <= OFF_W'(nh_reg + OW'(4));
                        res_reg.status  <= STAT_OK;
                        state_reg       <= ST_DONE;
                    end
                end
                ST_A_WF: begin
                    state_reg <= ST_A_WB;
                end
                ST_A_WB: begin
                    res_reg.valid   <= 1'b1;
                    res_reg.granted <= OFF_W'(nh_reg + OW'(4));
                    res_reg.status  <= STAT_OK;
                    state_reg       <= ST_DONE;
                end
                ST_F_WALK: begin
                    if (rd_end || (hit && !ram_rdata[0]) || (!hit && off_reg > h_reg)
                        || (!hit && next_past)) begin
                        res_reg.valid   <= 1'b1;
                        res_reg.granted <= '0;
                        res_reg.status  <= STAT_REJECT;
                        state_reg       <= ST_DONE;
                    end else if (hit) begin
                        bsize_reg <= rd_sz;
                        if (merge_left) begin
                            state_reg <= ST_F_LD;
                        end else begin
                            lsize_reg <= '0;
                            left_reg  <= h_reg;
                            state_reg <= ST_F_RD;
                        end
                    end else begin
                        off_reg <= walk_next;
                    end
                end
                ST_F_LD: begin
                    lsize_reg <= lsz_c;
                    left_reg  <= h_reg - lsz_c;
                    state_reg <= ST_F_RD;
                end
                ST_F_RD: begin
                    total_reg <= lsize_reg + bsize_reg + rsz_c;
                    state_reg <= ST_F_WL;
                end
                ST_F_WL: begin
                    state_reg <= ST_F_WF;
                end
                ST_F_WF: begin
                    res_reg.valid   <= 1'b1;
                    res_reg.granted <= '0;
                    res_reg.status  <= STAT_OK;
                    state_reg       <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        res_reg.valid <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BFHA_ASSERT(a_no_accept_in_init, aclk, aresetn, !heap_ready |-> !s_ready, "accept during init")
    `BFHA_ASSERT(a_idle_no_write, aclk, aresetn, (state_reg == ST_IDLE) |-> !ram_we, "idle write")
    `BFHA_ASSERT(a_walk_on_header, aclk, aresetn, ((state_reg == ST_A_WALK) || (state_reg == ST_F_WALK)) |-> ((off_reg < END_OFF) && (off_reg[2:0] == 3'd4)), "walk off header")
    `BFHA_ASSERT(a_grant_aligned, aclk, aresetn, (res_reg.valid && (res_reg.status == STAT_OK)) |-> (res_reg.granted[2:0] == 3'd0), "grant misaligned")
    `BFHA_ASSERT_NEXT(a_result_held, aclk, aresetn, res_reg.valid && !out_free, res_reg.valid && $stable(res_reg.granted), "result dropped")

endmodule

FILE: hw/rtl/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: heap memory, sequencer, result register.
//
// Each request is an allocate or a free over a boundary-tagged heap of HEAP_BYTES
// bytes held in a single-port-read, single-port-write word memory. An allocate's
// best-fit walk visits every block header in the heap (at most HEAP_BYTES/8),
// reading one header per cycle through the memory read port, then up to four tag
// writes follow. A free walks the headers up to the freed block; rejected frees
// of bad addresses finish without a walk. The block takes one request at a time and
// accepts the next as soon as the result has moved into the output register.
// After reset an initialization pass writes the whole heap image, all HEAP_BYTES/4
// words, during which s_ready stays low.
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [bfha_pkg::REQ_W-1:0] s_request_bytes,
    input  logic [bfha_pkg::OFF_W-1:0] s_payload_offset,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bfha_pkg::OFF_W-1:0] m_granted_offset,
    output logic [bfha_pkg::STATUS_W-1:0] m_status
);
    import bfha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES / 4);
    localparam int OW = $clog2(HEAP_BYTES) + 1;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              heap_ready;
    logic              out_free;
    res_t              res;

    logic                m_valid_reg;
    logic [OFF_W-1:0]    granted_reg;
    logic [STATUS_W-1:0] status_reg;

    bfha_heap #(
        .HEAP_BYTES (HEAP_BYTES),
        .AW         (AW)
    ) u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr   (ram_raddr),
        .rdata   (ram_rdata),
        .ready   (heap_ready)
    );

    bfha_seq #(
        .HEAP_BYTES (HEAP_BYTES),
        .AW         (AW),
        .OW         (OW)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_request_bytes  (s_request_bytes),
        .s_payload_offset (s_payload_offset),
        .heap_ready       (heap_ready),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .out_free         (out_free),
        .res              (res)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Load a finished result when the output stage is empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_valid_reg <= 1'b1;
            granted_reg <= res.granted;
            status_reg  <= res.status;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_offset = granted_reg;
    assign m_status         = status_reg;

endmodule

FILE: verif/tb_best_fit_heap_allocator.sv
// Self-checking testbench of the best-fit heap allocator: directed and random traffic.
`timescale 1ns / 100ps

module tb_best_fit_heap_allocator;
    import bfha_pkg::*;

    localparam int HEAP_BYTES = 4096;
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int unsigned END_MARK_OFF = HEAP_BYTES - 4;
    localparam int DRAIN_CYCLES = HEAP_BYTES / 8 + 100;

    typedef struct {
        logic [OFF_W-1:0] granted;
        status_t          status;
    } heap_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [REQ_W-1:0]      s_request_bytes;
    logic [OFF_W-1:0]      s_payload_offset;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OFF_W-1:0]      m_granted_offset;
    logic [STATUS_W-1:0]   m_status;

    // Mirror of the heap tags and the results still owed by the block
    logic [WORD_W-1:0] heap_image [HEAP_WORDS];
    heap_result_t      expected_results [$];
    logic [OFF_W-1:0]  live_blocks [$];
    heap_result_t      oldest_result;
    int                error_count = 0;
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;

    best_fit_heap_allocator #(
        .HEAP_BYTES(HEAP_BYTES)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_request_bytes  (s_request_bytes),
        .s_payload_offset (s_payload_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted_offset (m_granted_offset),
        .m_status         (m_status)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Tag access; anything outside the heap reads as zero and ignores writes
    function automatic int unsigned tag_rd(int unsigned off);
        int unsigned idx;
        idx = off >> 2;
        if (idx < HEAP_WORDS) begin
            return {16'd0, heap_image[idx]};
        end
        return 0;
    endfunction

    function automatic void tag_wr(int unsigned off, int unsigned val);
        int unsigned idx;
        idx = off >> 2;
        if (idx < HEAP_WORDS) begin
            heap_image[idx] = val[WORD_W-1:0];
        end
    endfunction

    // Load the image after reset: one free block spanning the heap, then the end mark
    function automatic void heap_reset();
        for (int i = 0; i < HEAP_WORDS; i++) begin
            heap_image[i] = '0;
        end
        tag_wr(4, HEAP_BYTES - 8 + 2);
        tag_wr(HEAP_BYTES - 8, HEAP_BYTES - 8);
        tag_wr(END_MARK_OFF, 1);
    endfunction

    // Walk the block list up to hdr; true only when hdr heads a busy block
    function automatic bit is_busy_header(int unsigned hdr);
        int unsigned off;
        int unsigned w;
        int unsigned sz;
        off = 4;
        while (off < END_MARK_OFF) begin
            w = tag_rd(off);
            sz = w & ~32'd7;
            if (w == 1 || sz == 0) break;
            if (off == hdr) return (w & 1) != 0;
            if (off > hdr) break;
            off += sz;
        end
        return 1'b0;
    endfunction

    function automatic heap_result_t best_fit_alloc(logic [REQ_W-1:0] nbytes);
        heap_result_t res;
        int unsigned size;
        int unsigned off;
        int unsigned w;
        int unsigned sz;
        int unsigned best;
        int unsigned bsize;
        int unsigned bdiff;
        int unsigned next_off;
        int unsigned next_w;
        int unsigned new_hdr;
        int unsigned tag_bits;
        bit          found;
        size = ((int'(nbytes) + 3) & ~32'd3) + 4;
        size = (size + 7) & ~32'd7;
        off = 4;
        best = 0;
        bsize = 0;
        bdiff = 0;
        found = 1'b0;
        // Scan every block; keep the first free block with least slack
        while (off < END_MARK_OFF) begin
            w = tag_rd(off);
            sz = w & ~32'd7;
            if (w == 1 || sz == 0) break;
            if ((w & 1) == 0 && sz >= size) begin
                if (!found || (sz - size) < bdiff) begin
                    found = 1'b1;
                    bdiff = sz - size;
                    best = off;
                    bsize = sz;
                end
            end
            off += sz;
        end
        res.granted = '0;
        if (!found) begin
            res.status = STAT_NO_FIT;
            return res;
        end
        // Carve from the top end and mark the follower's previous-busy bit
        next_off = best + bsize;
        next_w = tag_rd(next_off);
        new_hdr = best + bsize - size;
        tag_bits = 1;
        if (next_off != END_MARK_OFF && next_w != 1) tag_wr(next_off, next_w | 2);
        if (new_hdr == 4 || bdiff == 0) tag_bits = 3;
        tag_wr(new_hdr, size + tag_bits);
        if (bdiff != 0) begin
            tag_wr(new_hdr - 4, bdiff);
            tag_wr(best, bdiff + 2);
        end
        res.granted = OFF_W'(new_hdr + 4);
        res.status = STAT_OK;
        return res;
    endfunction

    function automatic heap_result_t coalescing_free(logic [OFF_W-1:0] poff);
        heap_result_t res;
        int unsigned p;
        int unsigned h;
        int unsigned w;
        int unsigned bsize;
        int unsigned left;
        int unsigned lsize;
        int unsigned right;
        int unsigned rw;
        int unsigned rsize;
        int unsigned total;
        p = poff;
        res.granted = '0;
        res.status = STAT_REJECT;
        if (p == 0 || (p & 7) != 0 || p >= HEAP_BYTES) return res;
        h = p - 4;
        if (!is_busy_header(h)) return res;
        w = tag_rd(h);
        bsize = w & ~32'd7;
        left = h;
        lsize = 0;
        rsize = 0;
        // Merge with a free block below, clearing its footer
        if ((w & 2) == 0 && h >= 8) begin
            lsize = tag_rd(h - 4);
            tag_wr(h - 4, 0);
            if (lsize > h) lsize = 0;
            left = h - lsize;
        end
        // Merge with a free block above, or clear its previous-busy bit
        right = h + bsize;
        rw = tag_rd(right);
        if (right < END_MARK_OFF && rw != 1) begin
            if ((rw & 1) == 0) begin
                rsize = rw & ~32'd7;
            end else begin
                tag_wr(right, rw & ~32'd2);
            end
        end
        total = lsize + bsize + rsize;
        tag_wr(left, total + 2);
        tag_wr(left + total - 4, total);
        res.status = STAT_OK;
        return res;
    endfunction

    // Predict one accepted request and track which payloads are live
    function automatic void predict_heap_op(logic op, logic [REQ_W-1:0] nbytes,
                                            logic [OFF_W-1:0] poff);
        heap_result_t res;
        if (op == OP_ALLOC) begin
            res = best_fit_alloc(nbytes);
            if (res.status == STAT_OK) live_blocks.push_back(res.granted);
        end else begin
            res = coalescing_free(poff);
            if (res.status == STAT_OK) begin
                for (int i = 0; i < live_blocks.size(); i++) begin
                    if (live_blocks[i] == poff) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
        end
        expected_results.push_back(res);
    endfunction

    // Send one request; hold valid until the transfer, then predict it
    task automatic issue_request(input logic op, input logic [REQ_W-1:0] nbytes,
                                 input logic [OFF_W-1:0] poff);
        int gap;
        gap = 0;
        @(negedge aclk);
        while (gap < 16 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            gap++;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_request_bytes <= nbytes;
        s_payload_offset <= poff;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_heap_op(op, nbytes, poff);
    endtask

    task automatic alloc_bytes(input int unsigned nbytes);
        issue_request(OP_ALLOC, nbytes[REQ_W-1:0], OFF_W'($urandom_range(4095)));
    endtask

    task automatic free_offset(input logic [OFF_W-1:0] poff);
        issue_request(OP_FREE, REQ_W'($urandom_range(8191)), poff);
    endtask

    // Hold the sender off until every owed result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Zero, oversized and widest requests; null, misaligned and stray frees
    task automatic test_edge_requests();
        alloc_bytes(0);
        alloc_bytes(4096);
        alloc_bytes(8191);
        free_offset(OFF_W'(0));
        free_offset(OFF_W'(4));
        free_offset(OFF_W'(4095));
        free_offset(OFF_W'(2048));
    endtask

    // Merge in both directions, double free, and a best-fit refit of a freed hole
    task automatic test_coalescing();
        logic [OFF_W-1:0] blk_a;
        logic [OFF_W-1:0] blk_b;
        logic [OFF_W-1:0] blk_c;
        alloc_bytes(100);
        blk_a = live_blocks[$];
        alloc_bytes(24);
        blk_b = live_blocks[$];
        alloc_bytes(100);
        blk_c = live_blocks[$];
        free_offset(blk_b);
        free_offset(blk_b);
        free_offset(blk_a);
        free_offset(blk_c);
        alloc_bytes(40);
        alloc_bytes(40);
        blk_b = live_blocks[$];
        alloc_bytes(40);
        free_offset(blk_b);
        alloc_bytes(36);
    endtask

    // Empty the heap, then take all of it in one exact fit
    task automatic test_whole_heap();
        logic [OFF_W-1:0] blk;
        while (live_blocks.size() != 0) begin
            free_offset(live_blocks[0]);
        end
        alloc_bytes(4085);
        alloc_bytes(4084);
        blk = live_blocks[$];
        alloc_bytes(0);
        free_offset(blk);
    endtask

    // Mixed traffic: allocations of varied sizes and frees, mostly of live blocks, some noise
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int pick;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        drain_results();
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            pick = $urandom_range(99);
            if (live_blocks.size() == 0 || pick < 55) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    alloc_bytes($urandom_range(64));
                end else if (pick < 90) begin
                    alloc_bytes($urandom_range(512, 65));
                end else if (pick < 97) begin
                    alloc_bytes($urandom_range(2048, 513));
                end else begin
                    alloc_bytes($urandom_range(8191));
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    free_offset(live_blocks[$urandom_range(live_blocks.size() - 1)]);
                end else if (pick < 90) begin
                    free_offset({9'($urandom_range(511)), 3'b000});
                end else begin
                    free_offset(OFF_W'($urandom_range(4095)));
                end
            end
        end
    endtask

    // Stall the result channel at the phase's rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: granted_offset %0d status %0d",
                       m_granted_offset, m_status);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_granted_offset !== oldest_result.granted) begin
                    $error("granted_offset: expected %0d, actual %0d",
                           oldest_result.granted, m_granted_offset);
                    error_count++;
                end
                if (m_status !== oldest_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, m_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_ALLOC;
        s_request_bytes = '0;
        s_payload_offset = '0;
        heap_reset();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_edge_requests();
        test_coalescing();
        test_whole_heap();
        test_random_traffic(175, 0, 0);
        test_random_traffic(175, 73, 0);
        test_random_traffic(175, 0, 73);
        test_random_traffic(175, 32, 32);

        // Wait out the owed results, then idle to catch any stray result
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
